/* rtl/pbst_pkg.sv */
// Shared types, widths and constants for the PID buffer size tuner.
`default_nettype none

package pbst_pkg;

    // Field widths
    localparam int GAIN_W  = 24;
    localparam int TGT_W   = 15;
    localparam int CEIL_W  = 40;
    localparam int IDLE_W  = 15;
    localparam int DT_W    = 16;
    localparam int LIM_W   = 24;
    localparam int CHG_W   = 25;

    // Internal datapath widths
    localparam int ERR_W   = 40;   // signed Q16.16 error
    localparam int PAIR_W  = ERR_W + 1;
    localparam int ACC_W   = 48;   // signed Q16.16 integral
    localparam int SUM_W   = 58;   // signed working sum
    localparam int NS_W    = 27;   // saturated candidate limit

    // Serial multiplier: MUL_A_W x MUL_B_W unsigned, one multiplier bit a cycle
    localparam int MUL_A_W   = 48;
    localparam int MUL_B_W   = 24;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int MUL_CNT_W = $clog2(MUL_B_W + 1);
    localparam logic [MUL_CNT_W-1:0] MUL_STEPS = MUL_CNT_W'(MUL_B_W);

    // Serial divider: DIV_N_W / DIV_D_W unsigned, one quotient bit a cycle
    localparam int DIV_N_W   = 40;
    localparam int DIV_D_W   = 16;
    localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(DIV_N_W);

    // Register port
    localparam int PADDR_W   = 6;
    localparam int PDATA_W   = 64;
    localparam int REG_IDX_W = 3;
    localparam int REG_LSB   = 3;

    // Arithmetic constants
    localparam logic [DIV_N_W-1:0]    SCALE_NUM   = 40'd1677721600;  // 100.0 in Q8.24
    localparam logic signed [32:0]    Q_ONE       = 33'sd65536;
    localparam logic [NS_W-1:0]       LIMIT_MIN   = 27'd100;
    localparam logic [NS_W-1:0]       LIMIT_MAX   = 27'd10000000;
    localparam logic [NS_W-1:0]       PREV_MARGIN = 27'd10;
    localparam logic [NS_W-1:0]       NS_SAT      = {1'b0, {(NS_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] ACC_FLOOR =
        {{(SUM_W-ACC_W+1){1'b1}}, {(ACC_W-1){1'b0}}};

    // Register reset values
    localparam logic [GAIN_W-1:0] GAIN_PROP_RST = 24'd65536;
    localparam logic [TGT_W-1:0]  TARGET_RST    = 15'd5120;
    localparam logic [CEIL_W-1:0] CEIL_RST      = 40'd6553600;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_GAIN_PROP  = 3'd0,
        REG_GAIN_INTEG = 3'd1,
        REG_GAIN_DERIV = 3'd2,
        REG_TARGET     = 3'd3,
        REG_CEILING    = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [GAIN_W-1:0] gain_prop;
        logic [GAIN_W-1:0] gain_integ;
        logic [GAIN_W-1:0] gain_deriv;
        logic [TGT_W-1:0]  target_idle;
        logic [CEIL_W-1:0] integ_ceiling;
    } t_cfg;

    typedef struct packed {
        logic               start;
        logic [MUL_A_W-1:0] mcand;
        logic [MUL_B_W-1:0] mplr;
    } t_mul_req;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] dividend;
        logic [DIV_D_W-1:0] divisor;
    } t_div_req;

    typedef enum logic [4:0] {
        S_IDLE,
        S_ERR,
        S_SDIV_GO,
        S_SDIV_WT,
        S_SMUL_GO,
        S_SMUL_WT,
        S_DDIV_GO,
        S_DDIV_WT,
        S_IMUL_GO,
        S_IMUL_WT,
        S_ACC,
        S_GP_GO,
        S_GP_WT,
        S_GI_GO,
        S_GI_WT,
        S_GD_GO,
        S_GD_WT,
        S_NS,
        S_PREV,
        S_NEXT,
        S_FIN
    } t_state;

endpackage

`default_nettype wire

/* rtl/pbst_regs.sv */
// Configuration register file behind the APB-style port.
`default_nettype none

module pbst_regs
    import pbst_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    t_cfg                 r_cfg;
    logic                 w_wr;
    logic [REG_IDX_W-1:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = paddr[REG_LSB +: REG_IDX_W];
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_prop     <= GAIN_PROP_RST;
            r_cfg.gain_integ    <= '0;
            r_cfg.gain_deriv    <= '0;
            r_cfg.target_idle   <= TARGET_RST;
            r_cfg.integ_ceiling <= CEIL_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_GAIN_PROP:  r_cfg.gain_prop     <= pwdata[GAIN_W-1:0];
                REG_GAIN_INTEG: r_cfg.gain_integ    <= pwdata[GAIN_W-1:0];
                REG_GAIN_DERIV: r_cfg.gain_deriv    <= pwdata[GAIN_W-1:0];
                REG_TARGET:     r_cfg.target_idle   <= pwdata[TGT_W-1:0];
                REG_CEILING:    r_cfg.integ_ceiling <= pwdata[CEIL_W-1:0];
                default: ;  // drop writes past the last register
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_GAIN_PROP:  prdata = {{(PDATA_W-GAIN_W){1'b0}}, r_cfg.gain_prop};
            REG_GAIN_INTEG: prdata = {{(PDATA_W-GAIN_W){1'b0}}, r_cfg.gain_integ};
            REG_GAIN_DERIV: prdata = {{(PDATA_W-GAIN_W){1'b0}}, r_cfg.gain_deriv};
            REG_TARGET:     prdata = {{(PDATA_W-TGT_W){1'b0}}, r_cfg.target_idle};
            REG_CEILING:    prdata = {{(PDATA_W-CEIL_W){1'b0}}, r_cfg.integ_ceiling};
            default:        prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/pbst_mul.sv */
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
`default_nettype none

module pbst_mul
    import pbst_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_mul_req          i_req,
    output logic              o_done,
    output logic [PROD_W-1:0] o_prod
);

    logic                 r_busy;
    logic                 r_done;
    logic [MUL_CNT_W-1:0] r_cnt;
    logic [MUL_A_W-1:0]   r_mcand;
    logic [MUL_A_W-1:0]   r_hi;
    logic [MUL_B_W-1:0]   r_lo;
    logic [MUL_A_W:0]     w_sum;

    // add the multiplicand when the current multiplier bit is set
    assign w_sum  = r_lo[0] ? ({1'b0, r_hi} + {1'b0, r_mcand}) : {1'b0, r_hi};
    assign o_done = r_done;
    assign o_prod = {r_hi, r_lo};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= MUL_STEPS;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == MUL_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_mcand <= i_req.mcand;
            r_hi    <= '0;
            r_lo    <= i_req.mplr;
        end else if (r_busy) begin
            // shift the partial product right by one
            r_hi <= w_sum[MUL_A_W:1];
            r_lo <= {w_sum[0], r_lo[MUL_B_W-1:1]};
        end
    end

endmodule

`default_nettype wire

/* rtl/pbst_div.sv */
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none

module pbst_div
    import pbst_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_div_req           i_req,
    output logic               o_done,
    output logic [DIV_N_W-1:0] o_quo
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_D_W-1:0]   r_dvs;
    logic [DIV_D_W-1:0]   r_rem;
    logic [DIV_N_W-1:0]   r_quo;
    logic [DIV_D_W:0]     w_trial;
    logic [DIV_D_W:0]     w_diff;
    logic                 w_ge;

    // bring down the next dividend bit and try a subtract
    assign w_trial = {r_rem, r_quo[DIV_N_W-1]};
    assign w_diff  = w_trial - {1'b0, r_dvs};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});
    assign o_done  = r_done;
    assign o_quo   = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_STEPS;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvs <= i_req.divisor;
            r_rem <= '0;
            r_quo <= i_req.dividend;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DIV_D_W-1:0] : w_trial[DIV_D_W-1:0];
            r_quo <= {r_quo[DIV_N_W-2:0], w_ge};
        end
    end

endmodule

`default_nettype wire

/* rtl/pid_buffer_size_tuner.sv */
// Top level of the PID buffer size tuner: sequencer, datapath and output register.
//
// Each input word is one re-evaluation of a channel's buffer size limit. The
// block forms the idle error (scaled by 100/target - 1 when it is negative),
// then runs a PID step in Q16.16: derivative over the elapsed ticks, a
// trapezoidal integral clamped between -2^47 and integ_ceiling, and the
// gain-weighted sum, which moves the stored limit. The neighbour rules and
// the 100..10000000 clamp follow, and one result word carries the new limit
// and the change. All wide arithmetic runs through one bit-serial multiplier
// (24 shift steps) and one bit-serial restoring divider (40 steps); when the
// idle reading is below target, the item takes one extra division and one
// extra product for the scale factor. One item is worked on at a time; the
// next is accepted in the idle state that follows the loading of the previous
// result into the output register, even if it has not been taken yet; a
// stalled result channel holds the block in its last step. Configuration may
// be written only while no item is in flight; registers lie at byte address
// 8*index on a 64-bit port.
`default_nettype none

module pid_buffer_size_tuner
    import pbst_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,

    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [PADDR_W-1:0]      paddr,
    input  logic [PDATA_W-1:0]      pwdata,
    output logic [PDATA_W-1:0]      prdata,
    output logic                    pready,

    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [IDLE_W-1:0]       i_idle_pct,
    input  logic [DT_W-1:0]         i_elapsed,
    input  logic                    i_has_prev,
    input  logic [LIM_W-1:0]        i_prev_limit,
    input  logic                    i_has_next,
    input  logic [LIM_W-1:0]        i_next_limit,

    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [LIM_W-1:0]        o_new_limit,
    output logic signed [CHG_W-1:0] o_limit_change
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    t_cfg w_cfg;

    pbst_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // ------------------------------------------------------------------
    // Serial arithmetic units
    // ------------------------------------------------------------------
    t_mul_req            w_mul_req;
    t_div_req            w_div_req;
    logic                w_mul_done;
    logic                w_div_done;
    logic [PROD_W-1:0]   w_prod;
    logic [DIV_N_W-1:0]  w_quo;

    pbst_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mul_req),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    pbst_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_state r_state, n_state;

    // captured input word
    logic [IDLE_W-1:0]        r_idle;
    logic [DT_W-1:0]          r_dt;
    logic                     r_has_prev;
    logic [LIM_W-1:0]         r_prev;
    logic                     r_has_next;
    logic [LIM_W-1:0]         r_next;

    // state carried from one evaluation to the next
    logic [LIM_W-1:0]         r_size;
    logic signed [ERR_W-1:0]  r_last;
    logic signed [ACC_W-1:0]  r_integ;

    // per-item working registers
    logic [MUL_B_W-2:0]       r_err0m;     // |idle - target| in Q7.16
    logic [30:0]              r_scale_m;
    logic                     r_scale_neg;
    logic signed [ERR_W-1:0]  r_err;
    logic [DIV_N_W-1:0]       r_deriv_m;
    logic                     r_deriv_neg;
    logic                     r_sum_neg;
    logic                     r_tsign;     // sign of the current gain product
    logic signed [SUM_W-1:0]  r_accw;
    logic signed [SUM_W-1:0]  r_v;
    logic [NS_W-1:0]          r_ns;

    // output register
    logic                     r_out_valid;
    logic [LIM_W-1:0]         r_new_limit;
    logic signed [CHG_W-1:0]  r_limit_change;

    // ------------------------------------------------------------------
    // Combinational datapath
    // ------------------------------------------------------------------
    logic                     w_accept;
    logic                     w_out_free;
    logic [TGT_W-1:0]         w_tgt;
    logic [TGT_W+1:0]         w_diff0;
    logic [TGT_W+1:0]         w_diff0_m;
    logic signed [32:0]       w_scale;
    logic [32:0]              w_scale_m;
    logic [ERR_W-2:0]         w_smag;
    logic signed [PAIR_W-1:0] w_pdiff;
    logic signed [PAIR_W-1:0] w_psum;
    logic [PAIR_W-1:0]        w_pdiff_m;
    logic [PAIR_W-1:0]        w_psum_m;
    logic [ERR_W-1:0]         w_err_m;
    logic [ACC_W-1:0]         w_integ_m;
    logic [GAIN_W-1:0]        w_gp_m;
    logic [GAIN_W-1:0]        w_gi_m;
    logic [GAIN_W-1:0]        w_gd_m;
    logic signed [SUM_W-1:0]  w_integ_x;
    logic signed [SUM_W-1:0]  w_delta;
    logic signed [SUM_W-1:0]  w_ceil_x;
    logic signed [SUM_W-1:0]  w_pq;
    logic [NS_W-1:0]          w_prev_m;
    logic [NS_W-1:0]          w_fin;
    logic [CHG_W-1:0]         w_chg;

    assign w_accept   = i_in_valid & ~o_in_stall;
    assign w_out_free = ~r_out_valid | ~i_out_stall;

    // a zero target counts as one
    assign w_tgt = (w_cfg.target_idle == '0) ? TGT_W'(1) : w_cfg.target_idle;

    // raw idle error in Q7.8, widened to hold the sign
    assign w_diff0   = {2'b00, r_idle} - {2'b00, w_tgt};
    assign w_diff0_m = w_diff0[TGT_W+1] ? (~w_diff0 + 1'b1) : w_diff0;

    // scale factor 100/target - 1 in Q16.16, from the divider quotient
    assign w_scale   = $signed({1'b0, w_quo[31:0]}) - Q_ONE;
    assign w_scale_m = w_scale[32] ? 33'(-w_scale) : 33'(w_scale);

    // magnitude of the scaled error, truncated toward zero
    assign w_smag = w_prod[ERR_W+14:16];

    // error minus and plus the previous error
    assign w_pdiff   = PAIR_W'(r_err) - PAIR_W'(r_last);
    assign w_psum    = PAIR_W'(r_err) + PAIR_W'(r_last);
    assign w_pdiff_m = w_pdiff[PAIR_W-1] ? PAIR_W'(-w_pdiff) : PAIR_W'(w_pdiff);
    assign w_psum_m  = w_psum[PAIR_W-1] ? PAIR_W'(-w_psum) : PAIR_W'(w_psum);

    assign w_err_m   = r_err[ERR_W-1] ? ERR_W'(-r_err) : ERR_W'(r_err);
    assign w_integ_m = r_integ[ACC_W-1] ? ACC_W'(-r_integ) : ACC_W'(r_integ);
    assign w_gp_m    = w_cfg.gain_prop[GAIN_W-1] ? (~w_cfg.gain_prop + 1'b1)
                                                 : w_cfg.gain_prop;
    assign w_gi_m    = w_cfg.gain_integ[GAIN_W-1] ? (~w_cfg.gain_integ + 1'b1)
                                                  : w_cfg.gain_integ;
    assign w_gd_m    = w_cfg.gain_deriv[GAIN_W-1] ? (~w_cfg.gain_deriv + 1'b1)
                                                  : w_cfg.gain_deriv;

    // trapezoid step: (err + last) * dt / 2, magnitude halved
    assign w_integ_x = SUM_W'(r_integ);
    assign w_delta   = $signed({{(SUM_W-(PROD_W-MUL_A_W+DIV_N_W-9)){1'b0}},
                                w_prod[55:1]});
    assign w_ceil_x  = $signed({{(SUM_W-CEIL_W){1'b0}}, w_cfg.integ_ceiling});

    // gain product, truncated to Q16.16
    assign w_pq = $signed({{(SUM_W-(PROD_W-16)){1'b0}}, w_prod[PROD_W-1:16]});

    assign w_prev_m = NS_W'(r_prev) + PREV_MARGIN;

    // final clamp and change against the stored limit
    always_comb begin
        if (r_ns < LIMIT_MIN) begin
            w_fin = LIMIT_MIN;
        end else if (r_ns > LIMIT_MAX) begin
            w_fin = LIMIT_MAX;
        end else begin
            w_fin = r_ns;
        end
    end
    assign w_chg = {1'b0, w_fin[LIM_W-1:0]} - {1'b0, r_size};

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (w_accept) n_state = S_ERR;
            S_ERR:     n_state = w_diff0[TGT_W+1] ? S_SDIV_GO : S_DDIV_GO;
            S_SDIV_GO: n_state = S_SDIV_WT;
            S_SDIV_WT: if (w_div_done) n_state = S_SMUL_GO;
            S_SMUL_GO: n_state = S_SMUL_WT;
            S_SMUL_WT: if (w_mul_done) n_state = S_DDIV_GO;
            S_DDIV_GO: n_state = S_DDIV_WT;
            S_DDIV_WT: if (w_div_done) n_state = S_IMUL_GO;
            S_IMUL_GO: n_state = S_IMUL_WT;
            S_IMUL_WT: if (w_mul_done) n_state = S_ACC;
            S_ACC:     n_state = S_GP_GO;
            S_GP_GO:   n_state = S_GP_WT;
            S_GP_WT:   if (w_mul_done) n_state = S_GI_GO;
            S_GI_GO:   n_state = S_GI_WT;
            S_GI_WT:   if (w_mul_done) n_state = S_GD_GO;
            S_GD_GO:   n_state = S_GD_WT;
            S_GD_WT:   if (w_mul_done) n_state = S_NS;
            S_NS:      n_state = S_PREV;
            S_PREV:    n_state = S_NEXT;
            S_NEXT:    n_state = S_FIN;
            S_FIN:     if (w_out_free) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs (input stall and unit launches)
    // ------------------------------------------------------------------
    always_comb begin
        o_in_stall = 1'b1;
        w_mul_req  = '0;
        w_div_req  = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
            end
            S_SDIV_GO: begin
                w_div_req.start    = 1'b1;
                w_div_req.dividend = SCALE_NUM;
                w_div_req.divisor  = DIV_D_W'(w_tgt);
            end
            S_SMUL_GO: begin
                w_mul_req.start = 1'b1;
                w_mul_req.mcand = MUL_A_W'(r_scale_m);
                w_mul_req.mplr  = MUL_B_W'(r_err0m);
            end
            S_DDIV_GO: begin
                w_div_req.start    = 1'b1;
                w_div_req.dividend = w_pdiff_m[DIV_N_W-1:0];
                w_div_req.divisor  = r_dt;
            end
            S_IMUL_GO: begin
                w_mul_req.start = 1'b1;
                w_mul_req.mcand = MUL_A_W'(w_psum_m[ERR_W-1:0]);
                w_mul_req.mplr  = MUL_B_W'(r_dt);
            end
            S_GP_GO: begin
                w_mul_req.start = 1'b1;
                w_mul_req.mcand = MUL_A_W'(w_err_m);
                w_mul_req.mplr  = w_gp_m;
            end
            S_GI_GO: begin
                w_mul_req.start = 1'b1;
                w_mul_req.mcand = w_integ_m;
                w_mul_req.mplr  = w_gi_m;
            end
            S_GD_GO: begin
                w_mul_req.start = 1'b1;
                w_mul_req.mcand = MUL_A_W'(r_deriv_m);
                w_mul_req.mplr  = w_gd_m;
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Control and persistent state
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_size      <= '0;
            r_last      <= '0;
            r_integ     <= '0;
        end else begin
            r_state <= n_state;

            // drop the result word once taken, reload at the end of an item
            if (r_state == S_FIN && w_out_free) begin
                r_out_valid <= 1'b1;
                r_size      <= w_fin[LIM_W-1:0];
            end else if (~i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            // clamp the integral: floor first, then the ceiling
            if (r_state == S_ACC) begin
                r_last <= r_err;
                if (r_accw < ACC_FLOOR) begin
                    r_integ <= ACC_W'(ACC_FLOOR);
                end else if (r_accw > w_ceil_x) begin
                    r_integ <= ACC_W'(w_ceil_x);
                end else begin
                    r_integ <= ACC_W'(r_accw);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Working registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_idle     <= i_idle_pct;
                    r_dt       <= (i_elapsed == '0) ? DT_W'(1) : i_elapsed;
                    r_has_prev <= i_has_prev;
                    r_prev     <= i_prev_limit;
                    r_has_next <= i_has_next;
                    r_next     <= i_next_limit;
                end
            end
            S_ERR: begin
                // hold the magnitude for scaling, or take a positive error as is
                r_err0m <= {w_diff0_m[TGT_W-1:0], 8'h00};
                r_err   <= $signed({{(ERR_W-TGT_W-8){1'b0}},
                                    w_diff0_m[TGT_W-1:0], 8'h00});
            end
            S_SDIV_WT: begin
                if (w_div_done) begin
                    r_scale_m   <= w_scale_m[30:0];
                    r_scale_neg <= w_scale[32];
                end
            end
            S_SMUL_WT: begin
                // the raw error is negative here, so the sign flips with the scale
                if (w_mul_done) begin
                    r_err <= r_scale_neg ? $signed({1'b0, w_smag})
                                         : $signed(ERR_W'(-$signed({1'b0, w_smag})));
                end
            end
            S_DDIV_GO: begin
                r_deriv_neg <= w_pdiff[PAIR_W-1];
            end
            S_DDIV_WT: begin
                if (w_div_done) begin
                    r_deriv_m <= w_quo;
                end
            end
            S_IMUL_GO: begin
                r_sum_neg <= w_psum[PAIR_W-1];
            end
            S_IMUL_WT: begin
                if (w_mul_done) begin
                    r_accw <= r_sum_neg ? (w_integ_x - w_delta) : (w_integ_x + w_delta);
                end
            end
            S_ACC: begin
                // start the sum from the stored limit in Q16.16
                r_v <= $signed({{(SUM_W-LIM_W-16){1'b0}}, r_size, 16'h0000});
            end
            S_GP_GO: begin
                r_tsign <= r_err[ERR_W-1] ^ w_cfg.gain_prop[GAIN_W-1];
            end
            S_GI_GO: begin
                r_tsign <= r_integ[ACC_W-1] ^ w_cfg.gain_integ[GAIN_W-1];
            end
            S_GD_GO: begin
                r_tsign <= r_deriv_neg ^ w_cfg.gain_deriv[GAIN_W-1];
            end
            S_GP_WT, S_GI_WT, S_GD_WT: begin
                if (w_mul_done) begin
                    r_v <= r_tsign ? (r_v - w_pq) : (r_v + w_pq);
                end
            end
            S_NS: begin
                // truncate toward zero; negatives and huge values saturate, as
                // the neighbour rules and the clamp treat them alike
                if (r_v[SUM_W-1]) begin
                    r_ns <= '0;
                end else if (|r_v[SUM_W-1:NS_W+15]) begin
                    r_ns <= NS_SAT;
                end else begin
                    r_ns <= {1'b0, r_v[NS_W+14:16]};
                end
            end
            S_PREV: begin
                if (r_has_prev && (r_ns < w_prev_m)) begin
                    r_ns <= w_prev_m;
                end
            end
            S_NEXT: begin
                if (r_has_next && (r_ns > NS_W'(r_next))) begin
                    r_ns <= r_ns + NS_W'(r_next[LIM_W-1:1]);
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    r_new_limit    <= w_fin[LIM_W-1:0];
                    r_limit_change <= $signed(w_chg);
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid    = r_out_valid;
    assign o_new_limit    = r_new_limit;
    assign o_limit_change = r_limit_change;

endmodule

`default_nettype wire
